// File: rtl/dis_pkg.sv
// Shared types, sizes and controller/datapath signal groups of the descending index sorter.
package dis_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 31;
    localparam int POS_W     = 6;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic pop;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic last_held;
    } dp_status_t;

endpackage

// File: rtl/dis_ctrl.sv
// Controller state machine: loads a set, then drains the ranked items.
module dis_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                set_end,
    input  dis_pkg::dp_status_t status,
    output logic                in_stall,
    output dis_pkg::ctrl_cmd_t  cmd
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign in_stall   = (state_reg != ST_LOAD);
    assign accept     = in_valid && !in_stall;
    assign cmd.insert = accept;
    assign cmd.pop    = (state_reg == ST_DRAIN) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && set_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cmd.pop && status.last_held)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/dis_datapath.sv
// Datapath: sorted insertion chain of cells, held count, overflow flag and output register.
module dis_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  dis_pkg::ctrl_cmd_t  cmd,
    input  dis_pkg::val_t       sales_count,
    input  logic                out_stall,
    output dis_pkg::dp_status_t status,
    output logic                out_valid,
    output dis_pkg::pos_t       item_position,
    output dis_pkg::val_t       ranked_sales,
    output logic                run_end,
    output logic                dropped_items
);

    dis_pkg::val_t cell_val_reg  [dis_pkg::MAX_ITEMS];
    dis_pkg::pos_t cell_pos_reg  [dis_pkg::MAX_ITEMS];
    dis_pkg::val_t cell_val_next [dis_pkg::MAX_ITEMS];
    dis_pkg::pos_t cell_pos_next [dis_pkg::MAX_ITEMS];

    dis_pkg::cnt_t count_reg;
    dis_pkg::cnt_t count_next;
    logic          ovf_reg;
    logic          ovf_next;

    logic          out_valid_reg;
    dis_pkg::pos_t out_pos_reg;
    dis_pkg::val_t out_val_reg;
    logic          out_end_reg;
    logic          out_drop_reg;

    logic [dis_pkg::MAX_ITEMS-1:0] ge;
    logic                          full;
    logic                          do_insert;

    assign full      = (count_reg == dis_pkg::cnt_t'(dis_pkg::MAX_ITEMS));
    assign do_insert = cmd.insert && !full;

    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.last_held = (count_reg == dis_pkg::cnt_t'(1));

    // Each held cell keeps its place when it is at least the new count, so ties stay in
    // arrival order; the first cell that is not takes the new count and the rest move up.
    genvar gi;
    generate
        for (gi = 0; gi < dis_pkg::MAX_ITEMS; gi++)
        begin : g_cell
            assign ge[gi] = (dis_pkg::cnt_t'(gi) < count_reg) &&
                            (cell_val_reg[gi] >= sales_count);

            if (gi == 0)
            begin : g_head
                always_comb
                begin
                    cell_val_next[gi] = cell_val_reg[gi];
                    cell_pos_next[gi] = cell_pos_reg[gi];
                    if (do_insert && !ge[gi])
                    begin
                        cell_val_next[gi] = sales_count;
                        cell_pos_next[gi] = dis_pkg::pos_t'(count_reg);
                    end
                    else if (cmd.pop)
                    begin
                        cell_val_next[gi] = cell_val_reg[gi+1];
                        cell_pos_next[gi] = cell_pos_reg[gi+1];
                    end
                end
            end
            else if (gi == dis_pkg::MAX_ITEMS - 1)
            begin : g_tail
                always_comb
                begin
                    cell_val_next[gi] = cell_val_reg[gi];
                    cell_pos_next[gi] = cell_pos_reg[gi];
                    if (do_insert && !ge[gi])
                    begin
                        if (ge[gi-1])
                        begin
                            cell_val_next[gi] = sales_count;
                            cell_pos_next[gi] = dis_pkg::pos_t'(count_reg);
                        end
                        else
                        begin
                            cell_val_next[gi] = cell_val_reg[gi-1];
                            cell_pos_next[gi] = cell_pos_reg[gi-1];
                        end
                    end
                end
            end
            else
            begin : g_mid
                always_comb
                begin
                    cell_val_next[gi] = cell_val_reg[gi];
                    cell_pos_next[gi] = cell_pos_reg[gi];
                    if (do_insert && !ge[gi])
                    begin
                        if (ge[gi-1])
                        begin
                            cell_val_next[gi] = sales_count;
                            cell_pos_next[gi] = dis_pkg::pos_t'(count_reg);
                        end
                        else
                        begin
                            cell_val_next[gi] = cell_val_reg[gi-1];
                            cell_pos_next[gi] = cell_pos_reg[gi-1];
                        end
                    end
                    else if (cmd.pop)
                    begin
                        cell_val_next[gi] = cell_val_reg[gi+1];
                        cell_pos_next[gi] = cell_pos_reg[gi+1];
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (do_insert)
        begin
            count_next = count_reg + dis_pkg::cnt_t'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - dis_pkg::cnt_t'(1);
        end
        if (cmd.insert && full)
        begin
            ovf_next = 1'b1;
        end
        else if (cmd.pop && status.last_held)
        begin
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < dis_pkg::MAX_ITEMS; i++)
        begin
            cell_val_reg[i] <= cell_val_next[i];
            cell_pos_reg[i] <= cell_pos_next[i];
        end
        if (cmd.pop)
        begin
            out_pos_reg  <= cell_pos_reg[0];
            out_val_reg  <= cell_val_reg[0];
            out_end_reg  <= status.last_held;
            out_drop_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cmd.pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign item_position = out_pos_reg;
    assign ranked_sales  = out_val_reg;
    assign run_end       = out_end_reg;
    assign dropped_items = out_drop_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dis_pkg::cnt_t'(dis_pkg::MAX_ITEMS))
        else $error("held count exceeds capacity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("pop from an empty chain");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.insert && cmd.pop))
        else $error("insert and pop in the same cycle");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= dis_pkg::cnt_t'(2)) |-> (cell_val_reg[0] >= cell_val_reg[1]))
        else $error("chain head out of order");

    a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (out_valid_reg && (out_val_reg == $past(cell_val_reg[0]))))
        else $error("output register not loaded from the chain head");

endmodule

// File: rtl/descending_index_sorter.sv
// Top level of the descending index sorter: stable descending ranking with arrival index.
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+-------------------------------------------------
//  input   | in        | in_valid/in_stall   | sales_count[30:0], set_end
//  output  | out       | out_valid/out_stall | item_position[5:0], ranked_sales[30:0],
//          |           |                     | run_end, dropped_items
//
// Each input transaction is placed into the sorted insertion chain unless it is full, so a
// set is loaded at one item per clock. The transaction that carries set_end starts the drain:
// the held items leave from the head of the chain, one per cycle while the output is not
// stalled, and the input channel is stalled until the last held item has left. The output
// register decouples the two sides, so a stalled output holds its result while the chain
// waits. Reset clears the held count, the overflow flag, the controller state and the output
// valid; the cells need no clearing because only cells below the held count are ever read.
module descending_index_sorter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [30:0]          sales_count,
    input  logic                 set_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [5:0]           item_position,
    output logic [30:0]          ranked_sales,
    output logic                 run_end,
    output logic                 dropped_items
);

    // The controller only sees the input handshake, set_end and the status group; the rest of
    // the payload stays in the datapath.
    dis_pkg::ctrl_cmd_t  cmd;
    dis_pkg::dp_status_t status;

    dis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .set_end  (set_end),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    dis_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sales_count   (sales_count),
        .out_stall     (out_stall),
        .status        (status),
        .out_valid     (out_valid),
        .item_position (item_position),
        .ranked_sales  (ranked_sales),
        .run_end       (run_end),
        .dropped_items (dropped_items)
    );

endmodule
